// ===== rtl/phm_pkg.sv =====
// ----------------------------------------------------------------------------
// phm_pkg
// Shared types and constants for the probe health monitor.
// ----------------------------------------------------------------------------
package phm_pkg;

    // History ring geometry
    localparam int HIST_DEPTH = 16;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam int HIST_FILL_W = $clog2(HIST_DEPTH + 1);
    localparam int HIST_SUM_W = $clog2(3 * HIST_DEPTH);

    // Fixed field widths
    localparam int SLOT_W = 4;
    localparam int FILL_OUT_W = 5;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 240;

    localparam logic [7:0] THRESH_RESET = 8'd3;

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } fsm_t;

    typedef struct packed {
        logic        avail;
        logic [7:0]  status;
        logic [15:0] rtt;
        logic [15:0] fail_run;
        logic [31:0] time_ms;
    } hist_entry_t;

    typedef struct packed {
        logic              append;
        logic              clear;
        logic              rd_en;
        logic [SLOT_W-1:0] slot;
    } hist_ctrl_t;

endpackage

// ===== rtl/phm_history.sv =====
// ----------------------------------------------------------------------------
// phm_history
// Ring of history entries in a synchronous memory with head and fill
// tracking; reads are addressed from the oldest entry.
// ----------------------------------------------------------------------------
module phm_history
    import phm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hist_ctrl_t             ctrl,
    input  hist_entry_t            wr_entry,
    output hist_entry_t            rd_entry,
    output logic                   rd_hit,
    output logic [HIST_FILL_W-1:0] fill
);

    localparam logic [HIST_SUM_W-1:0] DEPTH_S = HIST_SUM_W'(HIST_DEPTH);
    localparam logic [HIST_IDX_W-1:0] LAST_IDX = HIST_IDX_W'(HIST_DEPTH - 1);
    localparam logic [HIST_FILL_W-1:0] DEPTH_F = HIST_FILL_W'(HIST_DEPTH);

    hist_entry_t mem [HIST_DEPTH];

    logic [HIST_IDX_W-1:0]  head_reg, head_next;
    logic [HIST_FILL_W-1:0] count_reg, count_next;
    logic                   hit_reg;
    hist_entry_t            rd_data_reg;

    logic [HIST_SUM_W-1:0]  sum;
    logic [HIST_SUM_W-1:0]  sum_wrap;
    logic [HIST_IDX_W-1:0]  rd_idx;
    logic                   hit_now;

    // Oldest entry sits at head - count; the sum stays below twice the
    // depth whenever the slot is inside the fill, so one correction suffices.
    always_comb
    begin
        sum = HIST_SUM_W'(head_reg) + DEPTH_S - HIST_SUM_W'(count_reg)
              + HIST_SUM_W'(ctrl.slot);
        sum_wrap = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
        rd_idx = sum_wrap[HIST_IDX_W-1:0];
        hit_now = (HIST_SUM_W'(ctrl.slot) < HIST_SUM_W'(count_reg));
    end

    always_comb
    begin
        head_next = head_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            head_next = '0;
            count_next = '0;
        end
        else if (ctrl.append)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            if (count_reg < DEPTH_F)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            count_reg <= count_next;
            if (ctrl.rd_en)
            begin
                hit_reg <= hit_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.append)
        begin
            mem[head_reg] <= wr_entry;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_entry = rd_data_reg;
    assign rd_hit = hit_reg;
    assign fill = count_reg;

endmodule

// ===== rtl/probe_health_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// probe_health_monitor_unit
// Health record of one probed target: counters, runs, response time extremes,
// availability and a history ring.
// ----------------------------------------------------------------------------
// A command beat is captured into registers when accepted in ST_IDLE. In
// ST_EXEC the counters are updated and the history ring may be written, the
// ring is cleared, or the ring read is issued; in ST_DONE the result is loaded
// into the output register, and only then can the next beat be accepted. The
// registered read of the history memory is why ST_DONE follows ST_EXEC. While
// a result waits for m_tready, one more beat is still accepted and then waits
// in ST_DONE until the output register frees; no further beat is accepted
// until then. The history memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module probe_health_monitor_unit
    import phm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // cfg_data: fail_threshold[7:0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: probe_ok[0], probe_status[8:1], probe_rtt_ms[24:9],
    //          time_ms[56:25], slot[60:57], zero fill[63:61]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: avail[0], status_code[8:1], rtt_ms[24:9], fail_run[40:25],
    //          success_run[72:41], sent_total[104:73], received_total[136:105],
    //          lost_total[168:137], rtt_min_ms[184:169], rtt_max_ms[200:185],
    //          event_time_ms[232:201], history_fill[237:233], zero fill[239:238]
    output logic [M_TDATA_W-1:0] m_tdata
);

    fsm_t state_reg, state_next;

    // Captured command beat
    logic [1:0]        cmd_reg;
    logic              ok_reg;
    logic [7:0]        st_in_reg;
    logic [15:0]       rtt_in_reg;
    logic [31:0]       time_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [7:0]  thresh_reg;
    logic        avail_reg, avail_next;
    logic [31:0] sent_reg, sent_next;
    logic [31:0] recv_reg, recv_next;
    logic [31:0] loss_reg, loss_next;
    logic [31:0] ok_run_reg, ok_run_next;
    logic [31:0] bad_run_reg, bad_run_next;
    logic [15:0] min_reg, min_next;
    logic [15:0] max_reg, max_next;
    logic [7:0]  last_st_reg, last_st_next;
    logic [15:0] last_rtt_reg, last_rtt_next;
    logic [31:0] chg_time_reg, chg_time_next;
    logic        any_ok_reg, any_ok_next;

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic        do_record;
    logic        load_out;
    logic [15:0] bad_sat;

    hist_ctrl_t             hctrl;
    hist_entry_t            wr_entry;
    hist_entry_t            rd_entry;
    logic                   rd_hit;
    logic [HIST_FILL_W-1:0] fill;

    hist_entry_t res_entry;

    assign cfg_ready = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    assign do_record = (state_reg == ST_EXEC) && (cmd_reg == CMD_RECORD);

    // Status update for a record command
    always_comb
    begin
        avail_next = avail_reg;
        sent_next = sent_reg;
        recv_next = recv_reg;
        loss_next = loss_reg;
        ok_run_next = ok_run_reg;
        bad_run_next = bad_run_reg;
        min_next = min_reg;
        max_next = max_reg;
        last_st_next = last_st_reg;
        last_rtt_next = last_rtt_reg;
        chg_time_next = chg_time_reg;
        any_ok_next = any_ok_reg;
        if (do_record)
        begin
            last_st_next = st_in_reg;
            last_rtt_next = rtt_in_reg;
            sent_next = sent_reg + 32'd1;
            if (ok_reg)
            begin
                recv_next = recv_reg + 32'd1;
                ok_run_next = ok_run_reg + 32'd1;
                bad_run_next = '0;
                if (rtt_in_reg < min_reg)
                begin
                    min_next = rtt_in_reg;
                end
                if (rtt_in_reg > max_reg)
                begin
                    max_next = rtt_in_reg;
                end
                any_ok_next = 1'b1;
                avail_next = 1'b1;
            end
            else
            begin
                loss_next = loss_reg + 32'd1;
                bad_run_next = bad_run_reg + 32'd1;
                ok_run_next = '0;
                if (bad_run_next >= {24'd0, thresh_reg})
                begin
                    avail_next = 1'b0;
                end
            end
            if (avail_next != avail_reg)
            begin
                chg_time_next = time_reg;
            end
        end
    end

    assign bad_sat = (bad_run_next[31:16] != 16'd0) ? 16'hFFFF : bad_run_next[15:0];

    always_comb
    begin
        wr_entry.avail = avail_next;
        wr_entry.status = last_st_next;
        wr_entry.rtt = last_rtt_next;
        wr_entry.fail_run = bad_sat;
        wr_entry.time_ms = time_reg;
    end

    always_comb
    begin
        hctrl.append = do_record && (!ok_reg || (avail_next != avail_reg));
        hctrl.clear = (state_reg == ST_EXEC) && (cmd_reg == CMD_CLEAR);
        hctrl.rd_en = (state_reg == ST_EXEC) && (cmd_reg == CMD_READ);
        hctrl.slot = slot_reg;
    end

    phm_history u_history
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (hctrl),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry),
        .rd_hit   (rd_hit),
        .fill     (fill)
    );

    // Result assembly; the entry fields come from the ring only on a read.
    always_comb
    begin
        res_entry.avail = avail_reg;
        res_entry.status = last_st_reg;
        res_entry.rtt = last_rtt_reg;
        res_entry.fail_run = (bad_run_reg[31:16] != 16'd0) ? 16'hFFFF : bad_run_reg[15:0];
        res_entry.time_ms = chg_time_reg;
        if (cmd_reg == CMD_READ)
        begin
            res_entry = rd_hit ? rd_entry : '0;
        end
        out_data_next = {2'b00,
                         FILL_OUT_W'(fill),
                         res_entry.time_ms,
                         any_ok_reg ? max_reg : 16'd0,
                         any_ok_reg ? min_reg : 16'd0,
                         loss_reg,
                         recv_reg,
                         sent_reg,
                         ok_run_reg,
                         res_entry.fail_run,
                         res_entry.rtt,
                         res_entry.status,
                         res_entry.avail};
    end

    always_comb
    begin
        state_next = state_reg;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thresh_reg <= THRESH_RESET;
            avail_reg <= 1'b0;
            sent_reg <= '0;
            recv_reg <= '0;
            loss_reg <= '0;
            ok_run_reg <= '0;
            bad_run_reg <= '0;
            min_reg <= 16'hFFFF;
            max_reg <= '0;
            last_st_reg <= '0;
            last_rtt_reg <= '0;
            chg_time_reg <= '0;
            any_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_reg <= CMD_RECORD;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= cfg_data;
            end
            avail_reg <= avail_next;
            sent_reg <= sent_next;
            recv_reg <= recv_next;
            loss_reg <= loss_next;
            ok_run_reg <= ok_run_next;
            bad_run_reg <= bad_run_next;
            min_reg <= min_next;
            max_reg <= max_next;
            last_st_reg <= last_st_next;
            last_rtt_reg <= last_rtt_next;
            chg_time_reg <= chg_time_next;
            any_ok_reg <= any_ok_next;
            out_valid_reg <= out_valid_next;
            if (s_tvalid && s_tready)
            begin
                cmd_reg <= s_tuser;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ok_reg <= s_tdata[0];
            st_in_reg <= s_tdata[8:1];
            rtt_in_reg <= s_tdata[24:9];
            time_reg <= s_tdata[56:25];
            slot_reg <= s_tdata[60:57];
        end
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/phm_checker.sv =====
// ----------------------------------------------------------------------------
// phm_checker
// Port-level checks for the probe health monitor, bound to the top level.
// ----------------------------------------------------------------------------
module phm_checker
    import phm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The history never reports more entries than the ring holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[237:233] <= 5'(HIST_DEPTH)))
        else $error("history fill beyond ring depth");

    // Minimum response time never exceeds the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[184:169] <= m_tdata[200:185]))
        else $error("response time minimum above maximum");

    // A command beat is never followed by another in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command is in progress");

endmodule

bind probe_health_monitor_unit phm_checker u_phm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
